// File: sv/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types, event codes and register defaults for the player mode
// controller with lock timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pmc_pkg;

	localparam int LockW  = 26;
	localparam int BlinkW = 16;
	localparam int VolW   = 8;
	localparam int EvW    = 4;
	localparam int CodeW  = 3;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 26;
	localparam int InDataW  = 16;
	localparam int OutDataW = 48;

	// event codes carried in req_type
	localparam logic [EvW-1:0] EV_TICK      = 4'd0;
	localparam logic [EvW-1:0] EV_BUTTON1   = 4'd1;
	localparam logic [EvW-1:0] EV_BUTTON2   = 4'd2;
	localparam logic [EvW-1:0] EV_BOTH      = 4'd3;
	localparam logic [EvW-1:0] EV_LINK_UP   = 4'd4;
	localparam logic [EvW-1:0] EV_LINK_DOWN = 4'd5;
	localparam logic [EvW-1:0] EV_CLIP_DONE = 4'd6;
	localparam logic [EvW-1:0] EV_LOCK_ON   = 4'd7;
	localparam logic [EvW-1:0] EV_LOCK_OFF  = 4'd8;
	localparam logic [EvW-1:0] EV_VOLUME    = 4'd9;
	localparam logic [EvW-1:0] EV_THEME     = 4'd10;

	// mode codes as seen on the result
	localparam logic [CodeW-1:0] CODE_IDLE   = 3'd0;
	localparam logic [CodeW-1:0] CODE_SONG   = 3'd1;
	localparam logic [CodeW-1:0] CODE_ANIMAL = 3'd2;
	localparam logic [CodeW-1:0] CODE_STREAM = 3'd3;
	localparam logic [CodeW-1:0] CODE_LOCK   = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_LOCK_DURATION = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_IDLE_BLINK    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SONG_BLINK    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ANIMAL_BLINK  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_STREAM_BLINK  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LOCK_BLINK    = 3'd5;

	localparam logic [LockW-1:0]  LOCK_DURATION_RST = 26'd1800000;
	localparam logic [BlinkW-1:0] IDLE_BLINK_RST    = 16'd2000;
	localparam logic [BlinkW-1:0] SONG_BLINK_RST    = 16'd500;
	localparam logic [BlinkW-1:0] ANIMAL_BLINK_RST  = 16'd300;
	localparam logic [BlinkW-1:0] STREAM_BLINK_RST  = 16'd100;
	localparam logic [BlinkW-1:0] LOCK_BLINK_RST    = 16'd1000;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_SONG   = 5'b00010,
		MODE_ANIMAL = 5'b00100,
		MODE_STREAM = 5'b01000,
		MODE_LOCK   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [LockW-1:0]  lock_duration;
		logic [BlinkW-1:0] idle_blink;
		logic [BlinkW-1:0] song_blink;
		logic [BlinkW-1:0] animal_blink;
		logic [BlinkW-1:0] stream_blink;
		logic [BlinkW-1:0] lock_blink;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic              lock_active;
		logic [LockW-1:0]  lock_elapsed;
		logic              return_to_lock;
		logic              led_on;
		logic [BlinkW-1:0] led_elapsed;
		logic [VolW-1:0]   volume;
	} state_t;

	typedef struct packed {
		logic [CodeW-1:0] mode;
		logic             mode_changed;
		logic             led_level;
		logic [VolW-1:0]  stored_volume;
		logic             volume_updated;
		logic             theme_updated;
		logic [LockW-1:0] lock_remaining_ms;
	} result_t;

	function automatic logic [CodeW-1:0] mode_code(input mode_t m);
		case (m)
			MODE_IDLE:   mode_code = CODE_IDLE;
			MODE_SONG:   mode_code = CODE_SONG;
			MODE_ANIMAL: mode_code = CODE_ANIMAL;
			MODE_STREAM: mode_code = CODE_STREAM;
			MODE_LOCK:   mode_code = CODE_LOCK;
			default:     mode_code = CODE_IDLE;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: sv/pmc_next.sv
// ----------------------------------------------------------------------------
// pmc_next
// Next-state and result logic for one event of the mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pmc_next (
	input  var pmc_pkg::state_t               cur,
	input  var pmc_pkg::cfg_t                 cfg,
	input  var logic [pmc_pkg::EvW-1:0]       req_type,
	input  var logic [pmc_pkg::VolW-1:0]      volume_value,
	output pmc_pkg::state_t                   nxt,
	output pmc_pkg::result_t                  res
);
	import pmc_pkg::*;

	logic              expired;
	logic [LockW-1:0]  lock_el_tick;
	logic [BlinkW-1:0] interval;
	logic              vol_upd;
	logic              theme_upd;

	assign expired = cur.lock_elapsed >= cfg.lock_duration;

	always_comb begin
		if (cur.lock_active && !expired) begin
			lock_el_tick = cur.lock_elapsed + LockW'(1);
		end else begin
			lock_el_tick = cur.lock_elapsed;
		end
	end

	always_comb begin
		nxt       = cur;
		vol_upd   = 1'b0;
		theme_upd = 1'b0;
		case (req_type)
			EV_TICK: begin
				nxt.lock_elapsed = lock_el_tick;
				if (cur.mode == MODE_LOCK && cur.lock_active &&
				    lock_el_tick >= cfg.lock_duration) begin
					nxt.lock_active  = 1'b0;
					nxt.lock_elapsed = '0;
					nxt.mode         = MODE_IDLE;
				end
				if (cur.led_elapsed != '1) begin
					nxt.led_elapsed = cur.led_elapsed + BlinkW'(1);
				end
			end
			EV_VOLUME: begin
				nxt.volume = volume_value;
				vol_upd    = 1'b1;
			end
			EV_THEME: begin
				theme_upd = 1'b1;
			end
			EV_LINK_UP: begin
				if (cur.mode == MODE_LOCK) begin
					nxt.return_to_lock = 1'b1;
				end
				nxt.mode = MODE_STREAM;
			end
			default: begin
				case (cur.mode)
					MODE_IDLE: begin
						if (req_type == EV_BUTTON1) begin
							nxt.mode = MODE_SONG;
						end else if (req_type == EV_BUTTON2) begin
							nxt.mode = MODE_ANIMAL;
						end else if (req_type == EV_LOCK_ON) begin
							nxt.lock_active  = 1'b1;
							nxt.lock_elapsed = '0;
							nxt.mode         = MODE_LOCK;
						end
					end
					MODE_SONG, MODE_ANIMAL: begin
						if (req_type == EV_BUTTON1) begin
							nxt.mode = MODE_SONG;
						end else if (req_type == EV_BUTTON2) begin
							nxt.mode = MODE_ANIMAL;
						end else if (req_type == EV_BOTH || req_type == EV_CLIP_DONE) begin
							nxt.mode = MODE_IDLE;
						end else if (req_type == EV_LOCK_ON) begin
							nxt.lock_active  = 1'b1;
							nxt.lock_elapsed = '0;
							nxt.mode         = MODE_LOCK;
						end
					end
					MODE_STREAM: begin
						if (req_type == EV_LINK_DOWN) begin
							if (cur.return_to_lock && cur.lock_active && !expired) begin
								nxt.mode = MODE_LOCK;
							end else begin
								nxt.lock_active  = 1'b0;
								nxt.lock_elapsed = '0;
								nxt.mode         = MODE_IDLE;
							end
							nxt.return_to_lock = 1'b0;
						end
					end
					MODE_LOCK: begin
						if (req_type == EV_LOCK_ON) begin
							nxt.lock_active  = 1'b1;
							nxt.lock_elapsed = '0;
						end else if (req_type == EV_LOCK_OFF) begin
							nxt.lock_active  = 1'b0;
							nxt.lock_elapsed = '0;
							nxt.mode         = MODE_IDLE;
						end
					end
					default: begin
						nxt.mode = MODE_IDLE;
					end
				endcase
			end
		endcase

		// blink check against the interval of the next mode
		case (nxt.mode)
			MODE_IDLE:   interval = cfg.idle_blink;
			MODE_SONG:   interval = cfg.song_blink;
			MODE_ANIMAL: interval = cfg.animal_blink;
			MODE_STREAM: interval = cfg.stream_blink;
			MODE_LOCK:   interval = cfg.lock_blink;
			default:     interval = cfg.idle_blink;
		endcase
		if (interval == '0) begin
			interval = BlinkW'(1);
		end
		if (nxt.led_elapsed >= interval) begin
			nxt.led_on      = !cur.led_on;
			nxt.led_elapsed = '0;
		end

		res.mode           = mode_code(nxt.mode);
		res.mode_changed   = nxt.mode != cur.mode;
		res.led_level      = nxt.led_on;
		res.stored_volume  = nxt.volume;
		res.volume_updated = vol_upd;
		res.theme_updated  = theme_upd;
		if (nxt.lock_active && nxt.lock_elapsed < cfg.lock_duration) begin
			res.lock_remaining_ms = cfg.lock_duration - nxt.lock_elapsed;
		end else begin
			res.lock_remaining_ms = '0;
		end
	end

endmodule

`default_nettype wire

// File: sv/player_mode_controller_with_lock_timer_top.sv
// ----------------------------------------------------------------------------
// player_mode_controller_with_lock_timer_top
// Five-mode player controller (idle, song, animal, streaming, locked) with a
// saturating lock timer and a per-mode LED blinker.
// ----------------------------------------------------------------------------
// Each event transfer on the slave stream yields exactly one result transfer
// on the master stream, presented in the cycle after acceptance. The block
// takes one event per clock: the event is decoded against the state registers
// in a single pass and the result lands in an output register, and a new
// event is taken whenever that register is empty or being drained in the same
// cycle, so a stalled master side stops intake only once a result is waiting.
// Ticks (req_type 0) advance the lock timer and the LED counter; all other
// events are button, link, clip, lock, volume and theme notices. Configuration
// writes are always accepted (cfg_ready is held high) and must be issued
// only while no result is outstanding; indexes 6 and 7 are dropped.
`default_nettype none

module player_mode_controller_with_lock_timer_top (
	input  var logic                              clk,
	input  var logic                              arst_n,
	// slave stream: [3:0] req_type, [11:4] volume_value, [15:12] zero
	input  var logic                              s_tvalid,
	output logic                                  s_tready,
	input  var logic [pmc_pkg::InDataW-1:0]       s_tdata,
	// master stream: [2:0] mode, [3] mode_changed, [4] led_level,
	// [12:5] stored_volume, [13] volume_updated, [14] theme_updated,
	// [40:15] lock_remaining_ms, [47:41] zero
	output logic                                  m_tvalid,
	input  var logic                              m_tready,
	output logic [pmc_pkg::OutDataW-1:0]          m_tdata,
	// configuration write channel
	input  var logic                              cfg_valid,
	output logic                                  cfg_ready,
	input  var logic [pmc_pkg::CfgIdxW-1:0]       cfg_index,
	input  var logic [pmc_pkg::CfgDataW-1:0]      cfg_data
);
	import pmc_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    m_tvalid_q;
	logic    in_xfer;

	// Accept while the output register is empty or drains this cycle.
	assign s_tready  = !m_tvalid_q || m_tready;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Hold configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_duration <= LOCK_DURATION_RST;
			cfg_q.idle_blink    <= IDLE_BLINK_RST;
			cfg_q.song_blink    <= SONG_BLINK_RST;
			cfg_q.animal_blink  <= ANIMAL_BLINK_RST;
			cfg_q.stream_blink  <= STREAM_BLINK_RST;
			cfg_q.lock_blink    <= LOCK_BLINK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOCK_DURATION: cfg_q.lock_duration <= cfg_data[LockW-1:0];
				REG_IDLE_BLINK:    cfg_q.idle_blink    <= cfg_data[BlinkW-1:0];
				REG_SONG_BLINK:    cfg_q.song_blink    <= cfg_data[BlinkW-1:0];
				REG_ANIMAL_BLINK:  cfg_q.animal_blink  <= cfg_data[BlinkW-1:0];
				REG_STREAM_BLINK:  cfg_q.stream_blink  <= cfg_data[BlinkW-1:0];
				REG_LOCK_BLINK:    cfg_q.lock_blink    <= cfg_data[BlinkW-1:0];
				default: ;
			endcase
		end
	end

	pmc_next u_next (
		.cur          (state_q),
		.cfg          (cfg_q),
		.req_type     (s_tdata[EvW-1:0]),
		.volume_value (s_tdata[EvW+VolW-1:EvW]),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// Advance the controller state on every accepted event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= MODE_IDLE;
			state_q.lock_active    <= 1'b0;
			state_q.lock_elapsed   <= '0;
			state_q.return_to_lock <= 1'b0;
			state_q.led_on         <= 1'b0;
			state_q.led_elapsed    <= '0;
			state_q.volume         <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// Output register: valid tracks a pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_xfer) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0,
	                   res_q.lock_remaining_ms,
	                   res_q.theme_updated,
	                   res_q.volume_updated,
	                   res_q.stored_volume,
	                   res_q.led_level,
	                   res_q.mode_changed,
	                   res_q.mode};

endmodule

`default_nettype wire
